// ===== sv/u8pc_pkg.sv =====
// Shared types, constants and the lead-byte decoder of the UTF-8 packer.
`timescale 1ns / 1ps

package u8pc_pkg;

  // One incoming byte of a character.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } u8pc_byte_t;

  // One finished character.
  typedef struct packed {
    logic [31:0] packed_rune;
    logic        length_error;
    logic        continuation_error;
    logic        overlong_error;
  } u8pc_rune_t;

  localparam logic [2:0]  COUNT_SAT   = 3'd5;
  localparam logic [31:0] MIN_TWO     = 32'h0000_C280;
  localparam logic [31:0] MIN_THREE   = 32'h00E0_A080;
  localparam logic [31:0] MIN_FOUR    = 32'hF090_8080;
  localparam logic [1:0]  CONT_TAG    = 2'b10;

  // Expected character length from the lead byte, 0 for an invalid lead.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

// ===== sv/u8pc_in_reg.sv =====
// Input register stage of the UTF-8 packer.
`timescale 1ns / 1ps

module u8pc_in_reg
  import u8pc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  u8pc_byte_t byte_word,
  input  logic       advance,
  output logic       held_valid,
  output u8pc_byte_t held_word
);

  // Stage holds while full and the core cannot move on.
  assign byte_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!byte_stall) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      held_word <= byte_word;
    end
  end

endmodule

// ===== sv/u8pc_core.sv =====
// Character state and result logic of the UTF-8 packer.
`timescale 1ns / 1ps

module u8pc_core
  import u8pc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  u8pc_byte_t cur,
  output logic       res_valid,
  output u8pc_rune_t res
);

  logic [31:0] acc;
  logic [2:0]  seen;
  logic [2:0]  expect_len;
  logic        bad;

  logic [31:0] acc_next;
  logic [2:0]  seen_next;
  logic [2:0]  expect_len_next;
  logic        bad_next;
  logic        first;

  always_comb begin
    first           = (seen == 3'd0);
    expect_len_next = first ? lead_length(cur.byte_in) : expect_len;
    acc_next        = first ? {24'd0, cur.byte_in} : {acc[23:0], cur.byte_in};
    bad_next        = first ? 1'b0 : (bad || (cur.byte_in[7:6] != CONT_TAG));
    seen_next       = (seen < COUNT_SAT) ? seen + 3'd1 : seen;

    res.packed_rune        = acc_next;
    res.length_error       = (seen_next != expect_len_next);
    res.continuation_error = bad_next;
    case (seen_next)
      3'd1:    res.overlong_error = 1'b0;
      3'd2:    res.overlong_error = (acc_next < MIN_TWO);
      3'd3:    res.overlong_error = (acc_next < MIN_THREE);
      default: res.overlong_error = (acc_next < MIN_FOUR);
    endcase
    res_valid = step && cur.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      seen       <= '0;
      expect_len <= '0;
      bad        <= 1'b0;
    end else if (step) begin
      if (cur.last_byte) begin
        acc        <= '0;
        seen       <= '0;
        expect_len <= '0;
        bad        <= 1'b0;
      end else begin
        acc        <= acc_next;
        seen       <= seen_next;
        expect_len <= expect_len_next;
        bad        <= bad_next;
      end
    end
  end

endmodule

// ===== sv/u8pc_out_reg.sv =====
// Result register of the UTF-8 packer.
`timescale 1ns / 1ps

module u8pc_out_reg
  import u8pc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       res_valid,
  input  u8pc_rune_t res,
  output logic       advance,
  output logic       rune_valid,
  input  logic       rune_stall,
  output u8pc_rune_t rune_word
);

  // Free when empty or being drained this cycle.
  assign advance = !rune_valid || !rune_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rune_valid <= 1'b0;
    end else if (advance) begin
      rune_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      rune_word <= res;
    end
  end

endmodule

// ===== sv/utf8_char_pack_check.sv =====
// Top level of the UTF-8 character packer and checker.
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Word
// byte     in         byte_valid/byte_stall   u8pc_byte_t  (byte_in, last_byte)
// rune     out        rune_valid/rune_stall   u8pc_rune_t  (packed_rune, 3 error flags)
//
// One byte is taken per cycle while rune_stall is low.
// The last byte of a character passes the input register, then
// the result register fed by the decode/pack logic in the core.
// Reset (rst, synchronous) empties both registers and clears the character state.
// While a rune waits under rune_stall the input register still takes one more
// byte; byte_stall rises only when both registers are full.

module utf8_char_pack_check
  import u8pc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  u8pc_byte_t byte_word,
  output logic       rune_valid,
  input  logic       rune_stall,
  output u8pc_rune_t rune_word
);

  logic       advance;     // result register can take a new entry
  logic       held_valid;  // input register holds a byte
  u8pc_byte_t held_word;
  logic       res_valid;   // core finishes a character this cycle
  u8pc_rune_t res;

  u8pc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .advance    (advance),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  // The character state steps only when the held byte moves on, so a
  // stalled rune never sees its state change underneath.
  u8pc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (held_valid && advance),
    .cur       (held_word),
    .res_valid (res_valid),
    .res       (res)
  );

  u8pc_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .rune_valid (rune_valid),
    .rune_stall (rune_stall),
    .rune_word  (rune_word)
  );

endmodule

// ===== sv/u8pc_checker.sv =====
// Port-level assertions for the UTF-8 packer, bound to the top level.
`timescale 1ns / 1ps

module u8pc_checker
  import u8pc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_stall,
  input u8pc_byte_t byte_word,
  input logic       rune_valid,
  input logic       rune_stall,
  input u8pc_rune_t rune_word
);

  // A stalled rune stays and holds its word.
  a_rune_hold: assert property (@(posedge clk) disable iff (rst)
    rune_valid && rune_stall |=> rune_valid && $stable(rune_word))
    else $error("rune changed while stalled");

  // Input side never stalls while the output side is free.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !rune_stall |-> !byte_stall)
    else $error("byte_stall without rune_stall");

  // A byte taken while the rune was blocked fills the input register.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    rune_valid && rune_stall && !$past(rst) &&
    $past(rune_valid && rune_stall && byte_valid && !byte_stall) |-> byte_stall)
    else $error("byte taken with both registers full");

  // Every overlong bound lies at or below the four-byte minimum.
  a_overlong_range: assert property (@(posedge clk) disable iff (rst)
    rune_valid && rune_word.overlong_error |-> rune_word.packed_rune < MIN_FOUR)
    else $error("overlong flag on a word above every minimum");

  // Output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rune_valid)
    else $error("rune_valid after reset");

endmodule

bind utf8_char_pack_check u8pc_checker u_u8pc_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .byte_word  (byte_word),
  .rune_valid (rune_valid),
  .rune_stall (rune_stall),
  .rune_word  (rune_word)
);
